// File: hdl/spr_pkg.sv
package spr_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        ACT_ADD            = 2'd0,
        ACT_REMOVE         = 2'd1,
        ACT_LOOKUP_PORT    = 2'd2,
        ACT_LOOKUP_SERVICE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUP       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_FIX,
        S_FIX_END,
        S_OUT
    } state_t;

    typedef struct packed {
        action_t             action;
        logic [DATA_W-1:0]   service_number;
        logic [DATA_W-1:0]   port_number;
        logic [DATA_W-1:0]   service_version;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   answer_value;
        logic                any_valid;
    } rsp_t;

    // One table entry as it sits in memory, age rank kept beside it.
    typedef struct packed {
        logic [DATA_W-1:0]   service;
        logic [DATA_W-1:0]   port;
        logic [DATA_W-1:0]   version;
    } entry_t;

    // Flags gathered by one pass over the table.
    typedef struct packed {
        logic                port_hit;
        logic                free_hit;
        logic                best_hit;
    } scan_flags_t;

endpackage

// File: hdl/spr_chan_if.sv
interface spr_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/spr_mem.sv
module spr_mem #(
    parameter int ENTRIES = spr_pkg::ENTRIES_DEF,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IW-1:0]     wr_addr,
    input  spr_pkg::entry_t   wr_data,
    input  logic [IW-1:0]     wr_rank,
    input  logic              rd_en,
    input  logic [IW-1:0]     rd_addr,
    output spr_pkg::entry_t   rd_data,
    output logic [IW-1:0]     rd_rank
);

    spr_pkg::entry_t mem_data [ENTRIES];
    logic [IW-1:0]   mem_rank [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_data[wr_addr] <= wr_data;
            mem_rank[wr_addr] <= wr_rank;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_data[rd_addr];
            rd_rank <= mem_rank[rd_addr];
        end
    end

endmodule

// File: hdl/spr_scan.sv
module spr_scan #(
    parameter int ENTRIES = spr_pkg::ENTRIES_DEF,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       eval,
    input  logic [IW-1:0]              eval_idx,
    input  logic                       eval_valid,
    input  spr_pkg::entry_t            rd_data,
    input  logic [IW-1:0]              rd_rank,
    input  logic [spr_pkg::DATA_W-1:0] svc_key,
    input  logic [spr_pkg::DATA_W-1:0] port_key,
    output spr_pkg::scan_flags_t       flags,
    output logic [IW-1:0]              port_idx,
    output logic [spr_pkg::DATA_W-1:0] port_svc,
    output logic [IW-1:0]              port_rank,
    output logic [IW-1:0]              free_idx,
    output logic [spr_pkg::DATA_W-1:0] best_port
);

    spr_pkg::scan_flags_t       flags_reg;
    logic [IW-1:0]              port_idx_reg;
    logic [spr_pkg::DATA_W-1:0] port_svc_reg;
    logic [IW-1:0]              port_rank_reg;
    logic [IW-1:0]              free_idx_reg;
    logic [spr_pkg::DATA_W-1:0] best_port_reg;
    logic [spr_pkg::DATA_W-1:0] best_ver_reg;
    logic [IW-1:0]              best_rank_reg;

    logic take_port;
    logic take_free;
    logic take_best;

    // A newer candidate wins on a higher version, or on an equal version
    // with an older age rank.
    always_comb
    begin
        take_port = eval && eval_valid && (rd_data.port == port_key) && !flags_reg.port_hit;
        take_free = eval && !eval_valid && !flags_reg.free_hit;
        take_best = eval && eval_valid && (rd_data.service == svc_key) &&
                    (!flags_reg.best_hit || (rd_data.version > best_ver_reg) ||
                     ((rd_data.version == best_ver_reg) && (rd_rank < best_rank_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clear)
        begin
            flags_reg <= '0;
        end
        else
        begin
            if (take_port)
            begin
                flags_reg.port_hit <= 1'b1;
            end
            if (take_free)
            begin
                flags_reg.free_hit <= 1'b1;
            end
            if (take_best)
            begin
                flags_reg.best_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_port)
        begin
            port_idx_reg  <= eval_idx;
            port_svc_reg  <= rd_data.service;
            port_rank_reg <= rd_rank;
        end
        if (take_free)
        begin
            free_idx_reg <= eval_idx;
        end
        if (take_best)
        begin
            best_port_reg <= rd_data.port;
            best_ver_reg  <= rd_data.version;
            best_rank_reg <= rd_rank;
        end
    end

    assign flags     = flags_reg;
    assign port_idx  = port_idx_reg;
    assign port_svc  = port_svc_reg;
    assign port_rank = port_rank_reg;
    assign free_idx  = free_idx_reg;
    assign best_port = best_port_reg;

endmodule

// File: hdl/service_port_registry_unit.sv
// A result is offered after the search pass over the table, and a remove that finds
// its port first runs a second pass over the table for the rank fix-up.
// A new request is taken only once the controller is back in idle; the table passes
// read one memory entry per cycle.
// Reset (rst_n, asynchronous, active low) clears the valid bits, the entry count,
// the controller and the output valid flag; the entry memory is not cleared.
module service_port_registry_unit #(
    parameter int ENTRIES = spr_pkg::ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spr_chan_if.sink   req,
    spr_chan_if.source rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    spr_pkg::state_t           state_reg, state_next;
    logic [IW-1:0]             cnt_reg, cnt_next;
    logic                      eval_vld_reg;
    logic [IW-1:0]             eval_idx_reg;
    spr_pkg::req_t             req_reg;
    logic [ENTRIES-1:0]        valid_reg, valid_next;
    logic [CW-1:0]             count_reg, count_next;
    spr_pkg::status_t          res_status_reg, res_status_next;
    logic [spr_pkg::DATA_W-1:0] res_answer_reg, res_answer_next;
    logic                      out_vld_reg;
    spr_pkg::rsp_t             out_data_reg;

    logic                      accept;
    logic                      rd_en;
    logic                      fix_mode;
    logic                      out_load;

    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    spr_pkg::entry_t           wr_data;
    logic [IW-1:0]             wr_rank;
    spr_pkg::entry_t           rd_data;
    logic [IW-1:0]             rd_rank;

    spr_pkg::scan_flags_t       flags;
    logic [IW-1:0]              port_idx;
    logic [spr_pkg::DATA_W-1:0] port_svc;
    logic [IW-1:0]              port_rank;
    logic [IW-1:0]              free_idx;
    logic [spr_pkg::DATA_W-1:0] best_port;

    // The controller takes one request at a time. The output register lets the
    // next request in while the previous result still waits for its transfer.
    assign req.ready = (state_reg == spr_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;

    // Both passes walk the memory from entry 0 to the last one, one read per
    // cycle. The read data is registered in the memory, tagged by eval_idx_reg.
    assign rd_en    = (state_reg == spr_pkg::S_SCAN) || (state_reg == spr_pkg::S_FIX);
    assign fix_mode = (state_reg == spr_pkg::S_FIX) || (state_reg == spr_pkg::S_FIX_END);
    assign out_load = (state_reg == spr_pkg::S_OUT) && (!out_vld_reg || rsp.ready);

    spr_mem #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .wr_rank (wr_rank),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data),
        .rd_rank (rd_rank)
    );

    // The search pass collects the port match, the lowest free slot and the
    // best entry of the requested service all at once.
    spr_scan #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept),
        .eval       (eval_vld_reg && !fix_mode),
        .eval_idx   (eval_idx_reg),
        .eval_valid (valid_reg[eval_idx_reg]),
        .rd_data    (rd_data),
        .rd_rank    (rd_rank),
        .svc_key    (req_reg.service_number),
        .port_key   (req_reg.port_number),
        .flags      (flags),
        .port_idx   (port_idx),
        .port_svc   (port_svc),
        .port_rank  (port_rank),
        .free_idx   (free_idx),
        .best_port  (best_port)
    );

    // Memory writes. An add writes its new entry in the decide cycle. During
    // the fix-up pass each still-valid entry younger than the removed one is
    // written back with its rank lowered by one, the cycle after its read.
    // The pass reads entry k+1 while it writes entry k, so the two never meet.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = free_idx;
        wr_data = '{service: req_reg.service_number,
                    port:    req_reg.port_number,
                    version: req_reg.service_version};
        wr_rank = count_reg[IW-1:0];
        if (fix_mode)
        begin
            wr_en   = eval_vld_reg && valid_reg[eval_idx_reg] && (rd_rank > port_rank);
            wr_addr = eval_idx_reg;
            wr_data = rd_data;
            wr_rank = rd_rank - IW'(1);
        end
        else if ((state_reg == spr_pkg::S_DECIDE) &&
                 (req_reg.action == spr_pkg::ACT_ADD) &&
                 !flags.port_hit && flags.free_hit)
        begin
            wr_en = 1'b1;
        end
    end

    // Sequencer: next state, pass counter, table bookkeeping and the result.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_answer_next = res_answer_reg;

        unique case (state_reg)
            spr_pkg::S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = spr_pkg::S_SCAN;
                end
            end
            spr_pkg::S_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = spr_pkg::S_SCAN_END;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            spr_pkg::S_SCAN_END:
            begin
                // The last read is evaluated here; the search flags are final
                // in the next cycle.
                state_next = spr_pkg::S_DECIDE;
            end
            spr_pkg::S_DECIDE:
            begin
                res_status_next = spr_pkg::ST_OK;
                res_answer_next = '0;
                state_next      = spr_pkg::S_OUT;
                unique case (req_reg.action)
                    spr_pkg::ACT_ADD:
                    begin
                        // A duplicate port is checked before a full table.
                        if (flags.port_hit)
                        begin
                            res_status_next = spr_pkg::ST_DUP;
                        end
                        else if (!flags.free_hit)
                        begin
                            res_status_next = spr_pkg::ST_FULL;
                        end
                        else
                        begin
                            valid_next[free_idx] = 1'b1;
                            count_next           = count_reg + CW'(1);
                        end
                    end
                    spr_pkg::ACT_REMOVE:
                    begin
                        if (!flags.port_hit)
                        begin
                            res_status_next = spr_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            valid_next[port_idx] = 1'b0;
                            count_next           = count_reg - CW'(1);
                            state_next           = spr_pkg::S_FIX;
                        end
                    end
                    spr_pkg::ACT_LOOKUP_PORT:
                    begin
                        if (flags.best_hit)
                        begin
                            res_answer_next = best_port;
                        end
                        else
                        begin
                            res_status_next = spr_pkg::ST_NOT_FOUND;
                        end
                    end
                    spr_pkg::ACT_LOOKUP_SERVICE:
                    begin
                        if (flags.port_hit)
                        begin
                            res_answer_next = port_svc;
                        end
                        else
                        begin
                            res_status_next = spr_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_status_next = spr_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            spr_pkg::S_FIX:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = spr_pkg::S_FIX_END;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            spr_pkg::S_FIX_END:
            begin
                state_next = spr_pkg::S_OUT;
            end
            spr_pkg::S_OUT:
            begin
                // Wait here only while the previous result is still unclaimed.
                if (out_load)
                begin
                    state_next = spr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spr_pkg::S_IDLE;
            cnt_reg      <= '0;
            eval_vld_reg <= 1'b0;
            valid_reg    <= '0;
            count_reg    <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            eval_vld_reg <= rd_en;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg   <= cnt_reg;
        res_status_reg <= res_status_next;
        res_answer_reg <= res_answer_next;
        if (accept)
        begin
            req_reg <= req.payload;
        end
        if (out_load)
        begin
            // The entry count is already updated by the time the result leaves.
            out_data_reg <= '{status:       res_status_reg,
                              answer_value: res_answer_reg,
                              any_valid:    (count_reg != '0)};
        end
    end

    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_data_reg;

endmodule

// File: hdl/spr_checker.sv
module spr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input spr_pkg::status_t           rsp_status,
    input logic [spr_pkg::DATA_W-1:0] rsp_answer,
    input logic                       rsp_any
);

    // A result that waits for its transfer keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_answer) && $stable(rsp_any))
        else $error("response changed while stalled");

    // Only a successful lookup carries an answer.
    a_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != spr_pkg::ST_OK) |-> (rsp_answer == '0))
        else $error("answer set on a failed request");

    // A full table or a duplicate port means the table is not empty.
    a_full_dup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == spr_pkg::ST_FULL) ||
                      (rsp_status == spr_pkg::ST_DUP)) |-> rsp_any)
        else $error("full or duplicate reported on an empty table");

    // Requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

endmodule

bind service_port_registry_unit spr_checker u_spr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.payload.status),
    .rsp_answer (rsp.payload.answer_value),
    .rsp_any    (rsp.payload.any_valid)
);
